// ----- hdl/tjd_pkg.sv -----
`default_nettype none
package tjd_pkg;

    localparam int WINDOW    = 32;
    localparam int STAMP_W   = 64;
    localparam int THR_W     = 40;
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int SLOT_W    = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam int DIV_CNT_W = $clog2(STAMP_W);
    localparam int EXT_W     = STAMP_W + 2;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(800 * 10000);

    // controller -> datapath
    typedef struct packed {
        logic capture;    // input transfer: form diff, fetch oldest entry
        logic div_start;  // launch sum / fill_count
        logic mean_load;  // latch mean, retire oldest entry from sum
        logic finish;     // compare, load result, write ring
    } tjd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
    } tjd_stat_t;

endpackage
`default_nettype wire

// ----- hdl/tjd_if.sv -----
`default_nettype none
interface tjd_stamp_if;
    import tjd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [STAMP_W-1:0] time_stamp;
    modport source (output valid, output time_stamp, input ready);
    modport sink   (input valid, input time_stamp, output ready);
endinterface

interface tjd_result_if;
    import tjd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      jump_found;
    logic signed [STAMP_W-1:0] step_diff;
    logic signed [STAMP_W-1:0] mean_diff;
    modport source (output valid, output jump_found, output step_diff,
                    output mean_diff, input ready);
    modport sink   (input valid, input jump_found, input step_diff,
                    input mean_diff, output ready);
endinterface

interface tjd_cfg_if;
    import tjd_pkg::*;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] jump_threshold;
    modport source (output valid, output jump_threshold, input ready);
    modport sink   (input valid, input jump_threshold, output ready);
endinterface
`default_nettype wire

// ----- hdl/tjd_divider.sv -----
`default_nettype none
module tjd_divider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tjd_pkg::STAMP_W-1:0] dividend,
    input  wire logic [tjd_pkg::FILL_W-1:0]  divisor,
    output logic                             done,
    output logic [tjd_pkg::STAMP_W-1:0]      quotient
);
    import tjd_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(STAMP_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [STAMP_W-1:0]   quo_reg;
    logic [FILL_W-1:0]    rem_reg;
    logic [FILL_W-1:0]    dsr_reg;

    logic [FILL_W:0]      rem_sh;
    logic                 fits;
    logic [FILL_W-1:0]    rem_diff;
    logic [FILL_W-1:0]    rem_next;
    logic [STAMP_W-1:0]   quo_next;

    // radix-2 restoring step, one quotient bit per cycle
    // when it fits, the difference is below the divisor, so FILL_W bits hold it
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[STAMP_W-1]};
        fits     = (rem_sh >= {1'b0, dsr_reg});
        rem_diff = rem_sh[FILL_W-1:0] - dsr_reg;
        rem_next = fits ? rem_diff : rem_sh[FILL_W-1:0];
        quo_next = {quo_reg[STAMP_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- hdl/tjd_datapath.sv -----
`default_nettype none
module tjd_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tjd_pkg::tjd_cmd_t                  cmd,
    output tjd_pkg::tjd_stat_t                      stat,
    input  wire logic signed [tjd_pkg::STAMP_W-1:0] time_stamp,
    input  wire logic                               cfg_write,
    input  wire logic [tjd_pkg::THR_W-1:0]          cfg_data,
    output logic                                    jump_found,
    output logic signed [tjd_pkg::STAMP_W-1:0]      step_diff,
    output logic signed [tjd_pkg::STAMP_W-1:0]      mean_diff
);
    import tjd_pkg::*;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    logic [THR_W-1:0]   thr_reg;
    logic [STAMP_W-1:0] prev_reg;
    logic [STAMP_W-1:0] sum_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [FILL_W-1:0]  fill_reg;

    logic [STAMP_W-1:0] diff_reg;
    logic [STAMP_W-1:0] mean_reg;
    logic [STAMP_W-1:0] old_q_reg;
    logic               sum_neg_reg;

    logic               res_jump_reg;
    logic [STAMP_W-1:0] res_diff_reg;
    logic [STAMP_W-1:0] res_mean_reg;

    logic [STAMP_W-1:0] ring_mem [WINDOW];

    logic               full;
    logic [STAMP_W-1:0] old_eff;
    logic [STAMP_W-1:0] sum_mag;
    logic               div_done;
    logic [STAMP_W-1:0] quotient;
    logic [STAMP_W-1:0] mean_next;
    logic [EXT_W-1:0]   diff_x;
    logic [EXT_W-1:0]   bound_x;
    logic               jump_next;

    // slots fill in order, so the slot being overwritten holds a live entry only once the window is full
    assign full    = (fill_reg == FILL_FULL);
    assign old_eff = full ? old_q_reg : '0;
    assign sum_mag = sum_reg[STAMP_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    tjd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_mag),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        if (fill_reg == '0)
            mean_next = diff_reg;
        else if (sum_neg_reg)
            mean_next = ~quotient + 1'b1;
        else
            mean_next = quotient;
        // exact compare of diff > mean + threshold, two guard bits
        diff_x    = {{2{diff_reg[STAMP_W-1]}}, diff_reg};
        bound_x   = {{2{mean_reg[STAMP_W-1]}}, mean_reg}
                  + {{(EXT_W - THR_W){1'b0}}, thr_reg};
        jump_next = ($signed(diff_x) > $signed(bound_x));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            prev_reg <= '0;
            sum_reg  <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (cfg_write)
                thr_reg <= cfg_data;
            if (cmd.capture)
                prev_reg <= time_stamp;
            if (cmd.mean_load)
                sum_reg <= sum_reg - old_eff;
            if (cmd.finish)
            begin
                sum_reg  <= sum_reg + diff_reg;
                slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                if (!full)
                    fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            diff_reg  <= time_stamp - prev_reg;
            old_q_reg <= ring_mem[slot_reg];
        end
        if (cmd.div_start)
            sum_neg_reg <= sum_reg[STAMP_W-1];
        if (cmd.mean_load)
            mean_reg <= mean_next;
        if (cmd.finish)
        begin
            ring_mem[slot_reg] <= diff_reg;
            res_jump_reg       <= jump_next;
            res_diff_reg       <= diff_reg;
            res_mean_reg       <= mean_reg;
        end
    end

    assign stat.div_done = div_done;
    assign jump_found    = res_jump_reg;
    assign step_diff     = res_diff_reg;
    assign mean_diff     = res_mean_reg;

endmodule
`default_nettype wire

// ----- hdl/tjd_ctrl.sv -----
`default_nettype none
module tjd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tjd_pkg::tjd_cmd_t       cmd,
    input  wire tjd_pkg::tjd_stat_t stat
);
    import tjd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MEAN,
        S_CMP
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.capture   = in_valid && (state_reg == S_IDLE);
        cmd.div_start = (state_reg == S_DIV_GO);
        cmd.mean_load = (state_reg == S_MEAN);
        cmd.finish    = (state_reg == S_CMP) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (stat.div_done)
                        state_reg <= S_MEAN;
                end
                S_MEAN:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ----- hdl/timestamp_jump_detector.sv -----
// One timestamp is handled at a time: the input is ready only while the controller is idle.
// The mean comes from the 64-step radix-2 divider
//   that forms ring_sum / fill_count one quotient bit per cycle.
// A new timestamp is taken while the previous result still waits downstream.
// Reset (rst_n, async, active low): threshold to 8000000, previous stamp,
//   sum, slot and fill count to zero; ring entries read as zero until written.
`default_nettype none
module timestamp_jump_detector (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tjd_stamp_if.sink    stamp,
    tjd_result_if.source result,
    tjd_cfg_if.sink      cfg
);
    import tjd_pkg::*;

    tjd_cmd_t  cmd;
    tjd_stat_t stat;

    // threshold register is written in any cycle; software must write it only
    // while the block is idle, as the block itself does not enforce this
    assign cfg.ready = 1'b1;

    // controller: sequences capture, divide, mean, compare/write-back
    tjd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stamp.valid),
        .in_ready  (stamp.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: difference, ring memory, running sum, divider, compare,
    // result register
    tjd_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .time_stamp (stamp.time_stamp),
        .cfg_write  (cfg.valid),
        .cfg_data   (cfg.jump_threshold),
        .jump_found (result.jump_found),
        .step_diff  (result.step_diff),
        .mean_diff  (result.mean_diff)
    );

`ifndef SYNTHESIS
    // one timestamp in flight: no transfer right after another
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (stamp.valid && stamp.ready) |=> !stamp.ready)
        else $error("input taken while an item is in flight");

    // a result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!result.valid || result.ready))
        else $error("result register overwritten");

    // commands are exclusive steps of the sequence
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.div_start, cmd.mean_load, cmd.finish}))
        else $error("overlapping datapath commands");

    // finishing an item raises result valid on the next edge
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> result.valid)
        else $error("finished item not presented");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_timestamp_jump_detector.sv -----
`timescale 1ns / 100ps

module tb_timestamp_jump_detector;

    import tjd_pkg::*;

    localparam int          CLK_PERIOD      = 10;
    localparam int          RESET_CYCLES    = 7;
    localparam int          ITEMS_PER_PHASE = 185;
    localparam int          DRAIN_CYCLES    = 100;
    localparam int          CYCLE_LIMIT     = 1000000;
    localparam int          PRESSURE_HOLD   = 2000;    // long enough to back up the input
    localparam int          MAX_PRINTED     = 50;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};
    localparam logic [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};

    // Idling per random phase: none, sender only, receiver only, both.
    localparam int SRC_IDLE_PCT[4]   = '{0, 72, 0, 33};
    localparam int SINK_STALL_PCT[4] = '{0, 0, 72, 33};

    // Nominal frame periods in 100 ns units (25, ~30, ~60, ~24 fps).
    localparam logic [STAMP_W-1:0] FRAME_PERIOD[4] = '{64'd400000, 64'd333667,
                                                      64'd166833, 64'd417083};

    typedef struct packed {
        logic               jump_found;
        logic [STAMP_W-1:0] step_diff;
        logic [STAMP_W-1:0] mean_diff;
    } jump_verdict_t;

    // Scoreboard: tracks the detector state, queues the verdict for every
    // stamp transfer and compares each result transfer against the oldest.
    class jump_scoreboard;
        logic [THR_W-1:0]   threshold;
        logic [STAMP_W-1:0] last_stamp;
        logic [STAMP_W-1:0] diff_ring[WINDOW];
        logic [STAMP_W-1:0] ring_sum;
        int unsigned        slot;
        int unsigned        fill;
        jump_verdict_t      verdict_q[$];
        int                 errors;

        function new();
            threshold  = THR_RESET;
            last_stamp = '0;
            foreach (diff_ring[i])
                diff_ring[i] = '0;
            ring_sum = '0;
            slot     = 0;
            fill     = 0;
            errors   = 0;
        endfunction

        function void set_threshold(input logic [THR_W-1:0] value);
            threshold = value;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        // Mean used for the next comparison; an empty window falls back on diff.
        function logic [STAMP_W-1:0] mean_for(input logic [STAMP_W-1:0] diff);
            logic signed [STAMP_W:0] num;
            logic signed [STAMP_W:0] den;
            if (fill == 0)
                return diff;
            num = {ring_sum[STAMP_W-1], ring_sum};
            den = (STAMP_W+1)'(fill);
            num = num / den;   // signed, truncates toward zero
            return num[STAMP_W-1:0];
        endfunction

        function void note_stamp(input logic [STAMP_W-1:0] stamp);
            jump_verdict_t           v;
            logic signed [STAMP_W+1:0] lhs;
            logic signed [STAMP_W+1:0] rhs;
            v.step_diff  = stamp - last_stamp;
            v.mean_diff  = mean_for(v.step_diff);
            // mean + threshold at two extra bits, so it cannot wrap
            lhs          = {{2{v.step_diff[STAMP_W-1]}}, v.step_diff};
            rhs          = {{2{v.mean_diff[STAMP_W-1]}}, v.mean_diff}
                         + {{(STAMP_W+2-THR_W){1'b0}}, threshold};
            v.jump_found = (lhs > rhs);
            verdict_q.push_back(v);

            last_stamp      = stamp;
            ring_sum        = ring_sum - diff_ring[slot] + v.step_diff;
            diff_ring[slot] = v.step_diff;
            slot            = (slot + 1 >= WINDOW) ? 0 : slot + 1;
            if (fill < WINDOW)
                fill++;
        endfunction

        task report(input string what, input logic [STAMP_W-1:0] want,
                    input logic [STAMP_W-1:0] got);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("ERROR @%0t: %s: expected %h, got %h", $realtime, what, want, got);
        endtask

        task check_result(input logic jump, input logic [STAMP_W-1:0] diff,
                          input logic [STAMP_W-1:0] mean);
            jump_verdict_t want;
            if (verdict_q.size() == 0)
            begin
                report("result with no stamp outstanding", '0, diff);
                return;
            end
            want = verdict_q.pop_front();
            if (jump !== want.jump_found)
                report("jump_found", STAMP_W'(want.jump_found), STAMP_W'(jump));
            if (diff !== want.step_diff)
                report("step_diff", want.step_diff, diff);
            if (mean !== want.mean_diff)
                report("mean_diff", want.mean_diff, mean);
        endtask

        task check_drained();
            if (verdict_q.size() != 0)
                report("results never delivered", '0, STAMP_W'(verdict_q.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    tjd_stamp_if  stamp_ch ();
    tjd_result_if result_ch ();
    tjd_cfg_if    cfg_ch ();

    timestamp_jump_detector u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stamp  (stamp_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    jump_scoreboard sb = new();

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_len       = 0;
    int hold_req_cnt   = 0;     // bumped by the stimulus to request a hold-off
    int hold_seen_cnt  = 0;     // last request taken up by the receiver
    int hold_left      = 0;
    int cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: checks every result transfer, then picks ready for the next
    // cycle. A hold-off request overrides the random stall while hold_left counts down.
    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.jump_found, result_ch.step_diff, result_ch.mean_diff);
        if (hold_req_cnt != hold_seen_cnt)
        begin
            hold_seen_cnt   <= hold_req_cnt;
            hold_left       <= hold_len;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offer one stamp, idling first at the phase rate. The scoreboard sees
    // the stamp at the edge where it transfers. valid stays high on return,
    // so back-to-back calls present a new stamp without a bubble.
    task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
        while ($urandom_range(99) < src_idle_pct)
        begin
            stamp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        stamp_ch.valid      <= 1'b1;
        stamp_ch.time_stamp <= stamp;
        @(posedge clk);
        while (!stamp_ch.ready)
            @(posedge clk);
        sb.note_stamp(stamp);
    endtask

    // Stamp that lands a given difference past the last accepted one.
    task automatic send_step(input logic [STAMP_W-1:0] diff);
        send_stamp(sb.last_stamp + diff);
    endtask

    // Every stamp yields a result, so an empty queue means the block is idle.
    task automatic wait_drained();
        stamp_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.jump_threshold <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sb.set_threshold(value);
    endtask

    // Mostly a steady frame cadence with jitter; the rest are steps placed
    // right at the jump boundary, genuine forward jumps, backward steps and
    // fully random stamps.
    task automatic send_random(input logic [STAMP_W-1:0] period);
        int unsigned        pick;
        logic [STAMP_W-1:0] step;
        pick = $urandom_range(99);
        if (pick < 65)
            step = period + STAMP_W'(int'($urandom_range(2000)) - 1000);
        else if (pick < 75)
            step = sb.mean_for(period) + STAMP_W'(sb.threshold)
                 + STAMP_W'(int'($urandom_range(4)) - 2);
        else if (pick < 83)
            step = period + ({$urandom, $urandom} >> $urandom_range(63, 20));
        else if (pick < 88)
            step = -STAMP_W'($urandom_range(5000000));
        else
        begin
            send_stamp({$urandom, $urandom});
            return;
        end
        send_step(step);
    endtask

    // Directed: the window is empty right after reset, so the first stamp
    // differs from zero and its mean is its own difference. While only one
    // entry is stored the mean can sit at the top of the range, where
    // mean + threshold no longer fits in 64 bits.
    task automatic run_directed();
        send_stamp(STAMP_MAX);                                  // empty window
        send_step(STAMP_MAX);                                   // mean max: no wrap
        send_step(STAMP_MAX);                                   // sum has wrapped
        send_step(STAMP_MIN);
        send_stamp(STAMP_MIN);
        send_stamp(STAMP_MAX);
        send_stamp('1);
        send_stamp('0);
        send_step(sb.mean_for('0) + STAMP_W'(sb.threshold));       // exactly at limit
        send_step(sb.mean_for('0) + STAMP_W'(sb.threshold) + 1);   // one past
        repeat (4)
            send_step(FRAME_PERIOD[0]);

        wait_drained();
        write_threshold('0);
        send_step(sb.mean_for('0));                             // equal to mean
        send_step(sb.mean_for('0) + 1);                         // just above
        send_step(-FRAME_PERIOD[0]);                            // backward

        wait_drained();
        write_threshold('1);
        send_step(sb.mean_for('0) + STAMP_W'(sb.threshold) + 1);
        send_step(sb.mean_for('0) + STAMP_W'(sb.threshold));
    endtask

    initial
    begin
        logic [THR_W-1:0] phase_thr;

        rst_n                 = 1'b0;
        stamp_ch.valid        = 1'b0;
        stamp_ch.time_stamp   = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.jump_threshold = '0;
        result_ch.ready       = 1'b0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       phase_thr = THR_RESET;
                1:       phase_thr = {THR_W'($urandom_range(255)) << 32} | THR_W'($urandom);
                2:       phase_thr = THR_W'($urandom_range(1000));
                default: phase_thr = '1;
            endcase
            wait_drained();
            write_threshold(phase_thr);
            src_idle_pct   = SRC_IDLE_PCT[ph];
            sink_stall_pct = SINK_STALL_PCT[ph];
            if (ph == 0)
            begin
                // receiver goes quiet while stamps keep coming at full rate
                hold_len     = PRESSURE_HOLD;
                hold_req_cnt = hold_req_cnt + 1;
            end
            repeat (ITEMS_PER_PHASE)
                send_random(FRAME_PERIOD[ph]);
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        sb.check_drained();

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
